### design/srsm_pkg.sv
`default_nettype none

package srsm_pkg;

    // Pattern storage and position chain sizing
    localparam int PATTERN_BYTES = 32;
    localparam int NUM_POS       = PATTERN_BYTES + 1;
    localparam int PAT_WORDS     = 4;
    localparam int WORD_W        = 64;
    localparam int LEN_W         = 6;
    localparam int PADDR_W       = 6;

    // Pattern metacharacters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    // Request kind carried on tuser
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } op_t;

    // Register map, index is paddr / 8
    typedef enum logic [2:0] {
        REG_PAT_WORD_0 = 3'd0,
        REG_PAT_WORD_1 = 3'd1,
        REG_PAT_WORD_2 = 3'd2,
        REG_PAT_WORD_3 = 3'd3,
        REG_PAT_LEN    = 3'd4
    } reg_idx_t;

    // Decoded pattern control for one position
    typedef struct packed {
        logic [7:0] ch;          // pattern byte at this position
        logic       used;        // position is below the pattern length
        logic       in_use;      // position is at or below the pattern length
        logic       last;        // position equals the pattern length (accept)
        logic       star;        // next pattern byte is a repeat mark
        logic       end_anchor;  // trailing end-of-text anchor
        logic       start;       // entry position of a fresh text
    } cell_ctrl_t;

    // Per-position status toward the match logic
    typedef struct packed {
        logic acc_old;      // accept position live before this request
        logic acc_new;      // accept position live after this request
        logic dollar_hit;   // end anchor position live before this request
    } cell_stat_t;

endpackage

`default_nettype wire

### design/srsm_decode.sv
`default_nettype none

module srsm_decode (
    input  wire logic [srsm_pkg::PAT_WORDS-1:0][srsm_pkg::WORD_W-1:0] pat_word,
    input  wire logic [srsm_pkg::LEN_W-1:0]                           pat_len,
    output srsm_pkg::cell_ctrl_t [srsm_pkg::NUM_POS-1:0]              ctrl,
    output logic                                                      anchored
);
    import srsm_pkg::*;

    logic [PAT_WORDS*WORD_W-1:0] pat_flat;
    logic [LEN_W-1:0]            len_clip;
    logic [PATTERN_BYTES-1:0]    nz;
    logic [PATTERN_BYTES-1:0]    used_b;
    logic [NUM_POS:0]            used_x;
    logic [7:0]                  ch_x [NUM_POS+1];

    assign pat_flat = pat_word;

    // Clip the programmed length to the storage size
    assign len_clip = (pat_len > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES) : pat_len;

    // Pattern bytes, zero past the storage size
    always_comb
    begin
        for (int k = 0; k <= NUM_POS; k++)
        begin
            if (k < PATTERN_BYTES)
            begin
                ch_x[k] = pat_flat[8*k +: 8];
            end
            else
            begin
                ch_x[k] = 8'h00;
            end
        end
    end

    // Pattern ends at the clipped length or at the first zero byte
    always_comb
    begin
        logic [PATTERN_BYTES-1:0] low_mask;
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            nz[k] = (pat_flat[8*k +: 8] != 8'h00);
        end
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            low_mask  = {PATTERN_BYTES{1'b1}} >> (PATTERN_BYTES - 1 - k);
            used_b[k] = (LEN_W'(k) < len_clip) && (&(nz | ~low_mask));
        end
    end

    assign used_x   = {2'b00, used_b};
    assign anchored = used_x[0] && (ch_x[0] == CH_CARET);

    // Per-position control
    always_comb
    begin
        for (int p = 0; p < NUM_POS; p++)
        begin
            ctrl[p].ch         = ch_x[p];
            ctrl[p].used       = used_x[p];
            ctrl[p].in_use     = (p == 0) ? 1'b1 : used_x[(p == 0) ? 0 : p - 1];
            ctrl[p].last       = ctrl[p].in_use & ~used_x[p];
            ctrl[p].star       = used_x[p+1] && (ch_x[p+1] == CH_STAR);
            ctrl[p].end_anchor = used_x[p] && !used_x[p+1] && (ch_x[p] == CH_DOLLAR);
            ctrl[p].start      = anchored ? (p == 1) : (p == 0);
        end
    end

endmodule

`default_nettype wire

### design/srsm_cell.sv
`default_nettype none

module srsm_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire srsm_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 fresh,
    input  wire logic                 step,
    input  wire logic                 clear,
    input  wire logic                 adv_in,
    input  wire logic                 skip_in,
    input  wire logic                 init_skip_in,
    output logic                      adv_out,
    output logic                      skip_out,
    output logic                      init_skip_out,
    output srsm_pkg::cell_stat_t      stat
);
    import srsm_pkg::*;

    logic act_reg;
    logic act_next;
    logic init_closed;
    logic old_bit;
    logic hit;
    logic stay;
    logic closed;

    // Start set of a fresh text, closed over repeat groups
    assign init_closed   = ctrl.start | init_skip_in;
    assign init_skip_out = ctrl.star & init_closed;

    // Current position bit, dropped past the pattern length
    assign old_bit = (fresh ? init_closed : act_reg) & ctrl.in_use;

    // Advance on a matching byte, stay on a repeat group
    assign hit     = (ctrl.ch == CH_DOT) || (ctrl.ch == text_byte);
    assign stay    = old_bit & ctrl.used & ctrl.star & hit;
    assign adv_out = old_bit & ctrl.used & ~ctrl.star & ~ctrl.end_anchor & hit;

    // Skip over a repeat group two positions ahead
    assign closed   = stay | adv_in | skip_in;
    assign skip_out = ctrl.star & closed;

    assign stat.acc_old    = old_bit & ctrl.last;
    assign stat.acc_new    = closed & ctrl.last;
    assign stat.dollar_hit = old_bit & ctrl.end_anchor;

    always_comb
    begin
        act_next = act_reg;
        if (clear)
        begin
            act_next = 1'b0;
        end
        else if (step)
        begin
            act_next = closed & ctrl.in_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule

`default_nettype wire

### design/simple_regex_stream_matcher_core.sv
`default_nettype none

// Stream matcher for a small regular expression held in configuration.
// Input stream: s_tdata carries one text byte, s_tuser selects the request
// kind (byte or end of text). A byte request moves the live pattern positions;
// an end request produces one result on m_tdata bit 0 (1 = pattern found in
// the text) and starts a fresh text.
// Each pattern position is a cell in a row; all cells update together, so one
// request is taken every cycle. The update of a request, including the skip
// over repeat groups that ripples along the row, completes in that cycle.
// The result of an end request appears on m_tvalid in the cycle after it is taken
// and sits in an output register until the receiver takes it.
// While that register is full and m_tready is low, s_tready is low.
// The pattern (four 64-bit words and a length) is written over the APB port
// at byte address 8*i, between requests; pready is always high.
// Reset clears the pattern, the live positions and the output register; the
// block is ready in the first cycle after reset.
module simple_regex_stream_matcher_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // stream in
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] text_byte
    input  wire logic [0:0]                   s_tuser,   // [0] op
    // stream out
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [7:0]                        m_tdata,   // [0] matched, [7:1] zero
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [srsm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [srsm_pkg::WORD_W-1:0]  pwdata,
    output logic [srsm_pkg::WORD_W-1:0]       prdata,
    output logic                              pready
);
    import srsm_pkg::*;

    logic [PAT_WORDS-1:0][WORD_W-1:0] pat_word_reg;
    logic [PAT_WORDS-1:0][WORD_W-1:0] pat_word_next;
    logic [LEN_W-1:0]                 pat_len_reg;
    logic [LEN_W-1:0]                 pat_len_next;
    logic                             fresh_reg;
    logic                             fresh_next;
    logic                             found_reg;
    logic                             found_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             out_matched_reg;
    logic                             out_matched_next;

    logic                             cfg_wr;
    reg_idx_t                         cfg_idx;
    logic                             in_acc;
    logic                             step;
    logic                             finish;

    cell_ctrl_t [NUM_POS-1:0]         ctrl;
    logic                             anchored;
    logic [NUM_POS-1:0]               adv_out_vec;
    logic [NUM_POS-1:0]               skip_out_vec;
    logic [NUM_POS-1:0]               init_skip_out_vec;
    logic [NUM_POS-1:0]               adv_in_vec;
    logic [NUM_POS-1:0]               skip_in_vec;
    logic [NUM_POS-1:0]               init_skip_in_vec;
    cell_stat_t                       stat [NUM_POS];
    logic                             old_acc;
    logic                             new_acc;
    logic                             dollar_acc;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);

    always_comb
    begin
        pat_word_next = pat_word_reg;
        pat_len_next  = pat_len_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PAT_WORD_0: pat_word_next[0] = pwdata;
                REG_PAT_WORD_1: pat_word_next[1] = pwdata;
                REG_PAT_WORD_2: pat_word_next[2] = pwdata;
                REG_PAT_WORD_3: pat_word_next[3] = pwdata;
                REG_PAT_LEN:    pat_len_next     = pwdata[LEN_W-1:0];
                default:        pat_len_next     = pat_len_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PAT_WORD_0: prdata = pat_word_reg[0];
            REG_PAT_WORD_1: prdata = pat_word_reg[1];
            REG_PAT_WORD_2: prdata = pat_word_reg[2];
            REG_PAT_WORD_3: prdata = pat_word_reg[3];
            REG_PAT_LEN:    prdata = WORD_W'(pat_len_reg);
            default:        prdata = '0;
        endcase
    end

    // Pattern decode
    srsm_decode u_decode (
        .pat_word (pat_word_reg),
        .pat_len  (pat_len_reg),
        .ctrl     (ctrl),
        .anchored (anchored)
    );

    // Request handshake
    assign s_tready = ~out_valid_reg | m_tready;
    assign in_acc   = s_tvalid & s_tready;
    assign step     = in_acc & (op_t'(s_tuser) == OP_BYTE);
    assign finish   = in_acc & (op_t'(s_tuser) == OP_END);

    // Neighbor links: advance by one, skip repeat groups by two
    assign adv_in_vec       = {adv_out_vec[NUM_POS-2:0], ~anchored};
    assign skip_in_vec      = {skip_out_vec[NUM_POS-3:0], 2'b00};
    assign init_skip_in_vec = {init_skip_out_vec[NUM_POS-3:0], 2'b00};

    for (genvar i = 0; i < NUM_POS; i++)
    begin : g_cell
        srsm_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl[i]),
            .text_byte     (s_tdata),
            .fresh         (fresh_reg),
            .step          (step),
            .clear         (finish),
            .adv_in        (adv_in_vec[i]),
            .skip_in       (skip_in_vec[i]),
            .init_skip_in  (init_skip_in_vec[i]),
            .adv_out       (adv_out_vec[i]),
            .skip_out      (skip_out_vec[i]),
            .init_skip_out (init_skip_out_vec[i]),
            .stat          (stat[i])
        );
    end

    // Gather accept and end-anchor hits from the row
    always_comb
    begin
        old_acc    = 1'b0;
        new_acc    = 1'b0;
        dollar_acc = 1'b0;
        for (int p = 0; p < NUM_POS; p++)
        begin
            old_acc    = old_acc | stat[p].acc_old;
            new_acc    = new_acc | stat[p].acc_new;
            dollar_acc = dollar_acc | stat[p].dollar_hit;
        end
    end

    // Text state and output register
    always_comb
    begin
        fresh_next       = fresh_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg;
        out_matched_next = out_matched_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            fresh_next = 1'b0;
            found_next = found_reg | old_acc | new_acc;
        end
        else if (finish)
        begin
            fresh_next       = 1'b1;
            found_next       = 1'b0;
            out_valid_next   = 1'b1;
            out_matched_next = found_reg | old_acc | dollar_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_word_reg    <= '0;
            pat_len_reg     <= '0;
            fresh_reg       <= 1'b1;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_matched_reg <= 1'b0;
        end
        else
        begin
            pat_word_reg    <= pat_word_next;
            pat_len_reg     <= pat_len_next;
            fresh_reg       <= fresh_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
            out_matched_reg <= out_matched_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_matched_reg};

`ifndef SYNTHESIS
    // A result only appears after an end request
    a_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(finish))
        else $error("result raised without an end request");

    // End request starts a fresh text with no early hit
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (fresh_reg && !found_reg))
        else $error("text state not cleared after end request");

    // A byte request leaves the fresh state
    a_byte_not_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> !fresh_reg)
        else $error("fresh flag held after a text byte");

    // Early hit never survives into a fresh text
    a_fresh_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> !found_reg)
        else $error("early hit set in a fresh text");
`endif

endmodule

`default_nettype wire
